// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the decoder modules.
// Needs a clk and an active-low rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/tgapsd_pkg.sv =====
// Types and constants for the TGA pixel stream decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tgapsd_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       has_alpha;
        logic [7:0] repeat_count;
        logic       last_pixel;
        logic       format_error;
    } out_item_t;

    // Classified pixel or error event passed from the parser to the formatter.
    typedef struct packed {
        logic [31:0] pixel;
        logic        is16;
        logic        is32;
        logic [7:0]  count;
        logic        last;
        logic        error;
    } evt_t;

    localparam int unsigned EVT_QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

// ===== rtl/core/tgapsd_front.sv =====
// Byte parser: header, id skip, pixel gathering, RLE packets, pixel count.
// Depends on tgapsd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tgapsd_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire tgapsd_pkg::in_item_t item,
    output logic                      evt_push,
    output tgapsd_pkg::evt_t          evt
);
    import tgapsd_pkg::*;

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_SKIP    = 3'd1;
    localparam logic [2:0] PH_RAW     = 3'd2;
    localparam logic [2:0] PH_RLE_HDR = 3'd3;
    localparam logic [2:0] PH_RLE_PIX = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;
    localparam logic [2:0] PH_ERROR   = 3'd6;

    localparam logic [7:0] TYPE_RLE     = 8'd10;
    localparam logic [4:0] OFF_ID_LEN   = 5'd0;
    localparam logic [4:0] OFF_TYPE     = 5'd2;
    localparam logic [4:0] OFF_WIDTH_LO = 5'd12;
    localparam logic [4:0] OFF_WIDTH_HI = 5'd13;
    localparam logic [4:0] OFF_HEIGHT_LO = 5'd14;
    localparam logic [4:0] OFF_HEIGHT_HI = 5'd15;
    localparam logic [4:0] OFF_DEPTH    = 5'd16;
    localparam logic [7:0] DEPTH_16     = 8'd16;
    localparam logic [7:0] DEPTH_24     = 8'd24;
    localparam logic [7:0] DEPTH_32     = 8'd32;
    localparam logic [7:0] RUN_FLAG     = 8'd128;
    localparam logic [7:0] RUN_BIAS     = 8'd127;

    logic [2:0]  phase_reg, phase_next;
    logic [4:0]  header_offset_reg, header_offset_next;
    logic [8:0]  id_skip_left_reg, id_skip_left_next;
    logic        is_rle_reg, is_rle_next;
    logic [15:0] image_width_reg, image_width_next;
    logic [15:0] image_height_reg, image_height_next;
    logic [7:0]  pixel_depth_reg, pixel_depth_next;
    logic [31:0] pixel_bytes_reg, pixel_bytes_next;
    logic [1:0]  byte_in_pixel_reg, byte_in_pixel_next;
    logic [7:0]  packet_left_reg, packet_left_next;
    logic        packet_is_run_reg, packet_is_run_next;
    logic [31:0] pixels_left_reg, pixels_left_next;

    logic [2:0]  phase_cur;
    logic [4:0]  offset_cur;
    logic [7:0]  d;
    logic [2:0]  need;
    logic [31:0] gathered;
    logic        complete;
    logic [7:0]  run_count;
    logic [31:0] pixels_after;

    assign d = item.data_byte;
    assign need = pixel_depth_reg[5:3];

    always_comb
    begin
        gathered = pixel_bytes_reg;
        if (byte_in_pixel_reg == 2'd0)
        begin
            gathered = {24'd0, d};
        end
        else
        begin
            gathered[8*byte_in_pixel_reg +: 8] = d;
        end
        complete = ({1'b0, byte_in_pixel_reg} + 3'd1) >= need;
    end

    always_comb
    begin
        if ({24'd0, packet_left_reg} < pixels_left_reg)
        begin
            run_count = packet_left_reg;
        end
        else
        begin
            run_count = pixels_left_reg[7:0];
        end
    end

    always_comb
    begin
        phase_cur  = item.start_of_file ? PH_HEADER : phase_reg;
        offset_cur = item.start_of_file ? 5'd0 : header_offset_reg;

        phase_next         = phase_cur;
        header_offset_next = offset_cur;
        id_skip_left_next  = id_skip_left_reg;
        is_rle_next        = is_rle_reg;
        image_width_next   = image_width_reg;
        image_height_next  = image_height_reg;
        pixel_depth_next   = pixel_depth_reg;
        pixel_bytes_next   = pixel_bytes_reg;
        byte_in_pixel_next = byte_in_pixel_reg;
        packet_left_next   = packet_left_reg;
        packet_is_run_next = packet_is_run_reg;
        pixels_left_next   = pixels_left_reg;
        pixels_after       = pixels_left_reg;

        evt_push = 1'b0;
        evt      = '0;
        evt.is16 = (pixel_depth_reg == DEPTH_16);
        evt.is32 = (pixel_depth_reg == DEPTH_32);

        unique case (phase_cur)
            PH_HEADER:
            begin
                unique case (offset_cur)
                    OFF_ID_LEN:    id_skip_left_next = {1'b0, d} + 9'd1;
                    OFF_TYPE:      is_rle_next = (d == TYPE_RLE);
                    OFF_WIDTH_LO:  image_width_next = {8'd0, d};
                    OFF_WIDTH_HI:  image_width_next = {d, image_width_reg[7:0]};
                    OFF_HEIGHT_LO: image_height_next = {8'd0, d};
                    OFF_HEIGHT_HI: image_height_next = {d, image_height_reg[7:0]};
                    default: ;
                endcase
                if (offset_cur < OFF_DEPTH)
                begin
                    header_offset_next = offset_cur + 5'd1;
                end
                else
                begin
                    pixel_depth_next   = d;
                    byte_in_pixel_next = 2'd0;
                    packet_left_next   = 8'd0;
                    packet_is_run_next = 1'b0;
                    pixels_left_next   = {16'd0, image_width_reg} * {16'd0, image_height_reg};
                    if (d == DEPTH_24 || d == DEPTH_32 || (!is_rle_reg && d == DEPTH_16))
                    begin
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                        evt_push   = 1'b1;
                        evt        = '0;
                        evt.error  = 1'b1;
                    end
                end
            end
            PH_SKIP:
            begin
                if (id_skip_left_reg != 9'd0)
                begin
                    id_skip_left_next = id_skip_left_reg - 9'd1;
                end
                if (id_skip_left_next == 9'd0)
                begin
                    if (pixels_left_reg == 32'd0)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = is_rle_reg ? PH_RLE_HDR : PH_RAW;
                    end
                end
            end
            PH_RAW:
            begin
                pixel_bytes_next   = gathered;
                byte_in_pixel_next = complete ? 2'd0 : byte_in_pixel_reg + 2'd1;
                if (complete)
                begin
                    pixels_after     = pixels_left_reg - 32'd1;
                    pixels_left_next = pixels_after;
                    evt_push         = 1'b1;
                    evt.pixel        = gathered;
                    evt.count        = 8'd1;
                    evt.last         = (pixels_after == 32'd0);
                    if (pixels_after == 32'd0)
                    begin
                        phase_next = PH_DONE;
                    end
                end
            end
            PH_RLE_HDR:
            begin
                if (d < RUN_FLAG)
                begin
                    packet_is_run_next = 1'b0;
                    packet_left_next   = d + 8'd1;
                end
                else
                begin
                    packet_is_run_next = 1'b1;
                    packet_left_next   = d - RUN_BIAS;
                end
                byte_in_pixel_next = 2'd0;
                phase_next         = PH_RLE_PIX;
            end
            PH_RLE_PIX:
            begin
                pixel_bytes_next   = gathered;
                byte_in_pixel_next = complete ? 2'd0 : byte_in_pixel_reg + 2'd1;
                if (complete)
                begin
                    if (packet_is_run_reg)
                    begin
                        evt.count        = run_count;
                        packet_left_next = 8'd0;
                    end
                    else
                    begin
                        evt.count        = 8'd1;
                        packet_left_next = (packet_left_reg != 8'd0) ?
                                           packet_left_reg - 8'd1 : 8'd0;
                    end
                    pixels_after     = pixels_left_reg - {24'd0, evt.count};
                    pixels_left_next = pixels_after;
                    evt_push         = 1'b1;
                    evt.pixel        = gathered;
                    evt.last         = (pixels_after == 32'd0);
                    if (pixels_after == 32'd0)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (packet_left_next == 8'd0)
                    begin
                        phase_next = PH_RLE_HDR;
                    end
                end
            end
            default: ;
        endcase

        if (!accept)
        begin
            evt_push = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HEADER;
            header_offset_reg <= 5'd0;
            id_skip_left_reg  <= 9'd0;
            is_rle_reg        <= 1'b0;
            image_width_reg   <= 16'd0;
            image_height_reg  <= 16'd0;
            pixel_depth_reg   <= 8'd0;
            pixel_bytes_reg   <= 32'd0;
            byte_in_pixel_reg <= 2'd0;
            packet_left_reg   <= 8'd0;
            packet_is_run_reg <= 1'b0;
            pixels_left_reg   <= 32'd0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            header_offset_reg <= header_offset_next;
            id_skip_left_reg  <= id_skip_left_next;
            is_rle_reg        <= is_rle_next;
            image_width_reg   <= image_width_next;
            image_height_reg  <= image_height_next;
            pixel_depth_reg   <= pixel_depth_next;
            pixel_bytes_reg   <= pixel_bytes_next;
            byte_in_pixel_reg <= byte_in_pixel_next;
            packet_left_reg   <= packet_left_next;
            packet_is_run_reg <= packet_is_run_next;
            pixels_left_reg   <= pixels_left_next;
        end
    end

    `ASSERT_NEVER(a_pix_count_zero, evt_push && !evt.error && evt.count == 8'd0, "pixel with zero count")
    `ASSERT_NEVER(a_pix_count_big, evt_push && evt.count > RUN_FLAG, "repeat count above 128")
    `ASSERT_CLK(a_last_done, evt_push && evt.last |=> phase_reg == PH_DONE, "image end not closed")

endmodule

`default_nettype wire

// ===== rtl/core/tgapsd_queue.sv =====
// Two-entry event queue between parser and formatter.
// Depends on tgapsd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tgapsd_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire tgapsd_pkg::evt_t wr_data,
    output logic                  q_full,
    input  wire logic             rd_en,
    output tgapsd_pkg::evt_t      rd_data,
    output logic                  q_empty
);
    import tgapsd_pkg::*;

    localparam int unsigned PtrW = $clog2(EVT_QUEUE_DEPTH);
    localparam int unsigned CntW = $clog2(EVT_QUEUE_DEPTH + 1);

    evt_t            slot_reg [EVT_QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg, count_next;

    assign q_full  = (count_reg == CntW'(EVT_QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !(rd_en && !q_empty))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en && !q_empty)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(EVT_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en && !q_empty)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(EVT_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `ASSERT_NEVER(a_q_overflow, wr_en && q_full, "write into full event queue")
    `ASSERT_NEVER(a_q_count, count_reg > CntW'(EVT_QUEUE_DEPTH), "queue count out of range")

endmodule

`default_nettype wire

// ===== rtl/core/tgapsd_back.sv =====
// Formatter: turns queued events into RGBA results held in the output register.
// Depends on tgapsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tgapsd_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire tgapsd_pkg::evt_t  q_data,
    output logic                   q_pop,
    input  wire logic              pop,
    output logic                   empty,
    output tgapsd_pkg::out_item_t  result
);
    import tgapsd_pkg::*;

    logic      valid_reg;
    out_item_t result_reg, result_next;

    assign empty  = !valid_reg;
    assign result = result_reg;
    assign q_pop  = !q_empty && (!valid_reg || pop);

    always_comb
    begin
        result_next = '0;
        if (q_data.is16)
        begin
            result_next.blue  = {q_data.pixel[4:0], 3'b000};
            result_next.green = {q_data.pixel[9:5], 3'b000};
            result_next.red   = {q_data.pixel[14:10], 3'b000};
        end
        else
        begin
            result_next.blue  = q_data.pixel[7:0];
            result_next.green = q_data.pixel[15:8];
            result_next.red   = q_data.pixel[23:16];
            result_next.alpha = q_data.is32 ? q_data.pixel[31:24] : 8'd0;
        end
        result_next.has_alpha    = q_data.is32;
        result_next.repeat_count = q_data.count;
        result_next.last_pixel   = q_data.last;
        result_next.format_error = q_data.error;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tga_pixel_stream_decoder.sv =====
// Top level of the TGA pixel stream decoder: parser, event queue, formatter.
// Depends on tgapsd_pkg, tgapsd_front, tgapsd_queue and tgapsd_back.
`timescale 1ns / 1ps
`default_nettype none

// Takes a TGA file one byte per cycle while full is low and gives decoded
// RGBA pixels. The parser handles each byte in the cycle it is accepted;
// full rises only when the two-entry event queue and the output register
// are both occupied because results are not being popped. A completed pixel
// goes through the event queue and then the output register. An RLE run
// packet comes out as one result with repeat_count set; raw pixels have a
// count of one. An unsupported depth gives a single result with format_error
// set, after which bytes are ignored until start_of_file.
module tga_pixel_stream_decoder (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire tgapsd_pkg::in_item_t  item,
    output logic                       empty,
    input  wire logic                  pop,
    output tgapsd_pkg::out_item_t      result
);
    import tgapsd_pkg::*;

    logic accept;
    logic evt_push;
    evt_t evt;
    logic q_empty;
    logic q_pop;
    evt_t q_data;

    assign accept = push && !full;

    tgapsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .evt_push (evt_push),
        .evt      (evt)
    );

    tgapsd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (evt_push),
        .wr_data (evt),
        .q_full  (full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .q_empty (q_empty)
    );

    tgapsd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

`default_nettype wire

// ===== tb/tga_pixel_checker.sv =====
`timescale 1ns / 1ps
// Checker for the TGA pixel stream decoder: follows both queue sides, predicts
// the pixel results of every accepted byte and compares them in order.
// Depends on tgapsd_pkg.
module tga_pixel_checker #(
    parameter logic [7:0] IMAGE_TYPE_RLE = 8'd10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  tgapsd_pkg::in_item_t  item,
    input  logic                  empty,
    input  logic                  pop,
    input  tgapsd_pkg::out_item_t result,
    output int                    mismatches,
    output int                    outstanding
);
    import tgapsd_pkg::*;

    typedef enum logic [2:0] {
        ST_HEADER,
        ST_SKIP,
        ST_RAW,
        ST_RLE_HDR,
        ST_RLE_PIX,
        ST_DONE,
        ST_ERROR
    } parse_state_t;

    parse_state_t state;
    logic [4:0]   hdr_pos;
    logic [8:0]   skip_left;
    logic         rle;
    logic [15:0]  width;
    logic [15:0]  height;
    logic [7:0]   depth;
    logic [31:0]  pix_word;
    logic [1:0]   byte_idx;
    logic [7:0]   packet_left;
    logic         packet_run;
    logic [31:0]  pixels_left;
    out_item_t    expected_pixels[$];

    function automatic bit gather_byte(input logic [7:0] d);
        int need;
        need = int'(depth[5:3]);
        if (byte_idx == 2'd0)
            pix_word = {24'h0, d};
        else
            pix_word |= {24'h0, d} << (8 * byte_idx);
        if (int'(byte_idx) + 1 >= need)
        begin
            byte_idx = 2'd0;
            return 1'b1;
        end
        byte_idx = byte_idx + 2'd1;
        return 1'b0;
    endfunction

    function automatic out_item_t make_pixel(input logic [31:0] count, input bit last);
        out_item_t px;
        px = '0;
        if (depth == 8'd16)
        begin
            px.blue  = {pix_word[4:0], 3'b000};
            px.green = {pix_word[9:5], 3'b000};
            px.red   = {pix_word[14:10], 3'b000};
        end
        else
        begin
            px.blue  = pix_word[7:0];
            px.green = pix_word[15:8];
            px.red   = pix_word[23:16];
            if (depth == 8'd32)
                px.alpha = pix_word[31:24];
        end
        px.has_alpha    = (depth == 8'd32);
        px.repeat_count = count[7:0];
        px.last_pixel   = last;
        return px;
    endfunction

    function automatic bit decode_byte(input in_item_t tr, output out_item_t px);
        logic [7:0]  d;
        logic [31:0] count;
        d  = tr.data_byte;
        px = '0;
        if (tr.start_of_file)
        begin
            state   = ST_HEADER;
            hdr_pos = 5'd0;
        end
        case (state)
            ST_HEADER:
            begin
                case (hdr_pos)
                    5'd0:  skip_left = {1'b0, d} + 9'd1;
                    5'd2:  rle = (d == IMAGE_TYPE_RLE);
                    5'd12: width = {8'h00, d};
                    5'd13: width[15:8] = d;
                    5'd14: height = {8'h00, d};
                    5'd15: height[15:8] = d;
                    default: ;
                endcase
                if (hdr_pos < 5'd16)
                begin
                    hdr_pos = hdr_pos + 5'd1;
                    return 1'b0;
                end
                depth       = d;
                byte_idx    = 2'd0;
                packet_left = 8'd0;
                packet_run  = 1'b0;
                pixels_left = {16'h0, width} * {16'h0, height};
                if (d == 8'd24 || d == 8'd32 || (!rle && d == 8'd16))
                begin
                    state = ST_SKIP;
                    return 1'b0;
                end
                state = ST_ERROR;
                px.format_error = 1'b1;
                return 1'b1;
            end
            ST_SKIP:
            begin
                if (skip_left != 9'd0)
                    skip_left = skip_left - 9'd1;
                if (skip_left == 9'd0)
                begin
                    if (pixels_left == 32'd0)
                        state = ST_DONE;
                    else
                        state = rle ? ST_RLE_HDR : ST_RAW;
                end
                return 1'b0;
            end
            ST_RAW:
            begin
                if (!gather_byte(d))
                    return 1'b0;
                pixels_left = pixels_left - 32'd1;
                px = make_pixel(32'd1, pixels_left == 32'd0);
                if (pixels_left == 32'd0)
                    state = ST_DONE;
                return 1'b1;
            end
            ST_RLE_HDR:
            begin
                if (d < 8'd128)
                begin
                    packet_run  = 1'b0;
                    packet_left = d + 8'd1;
                end
                else
                begin
                    packet_run  = 1'b1;
                    packet_left = d - 8'd127;
                end
                byte_idx = 2'd0;
                state    = ST_RLE_PIX;
                return 1'b0;
            end
            ST_RLE_PIX:
            begin
                if (!gather_byte(d))
                    return 1'b0;
                if (packet_run)
                begin
                    count = ({24'h0, packet_left} < pixels_left) ? {24'h0, packet_left}
                                                                 : pixels_left;
                    packet_left = 8'd0;
                end
                else
                begin
                    count = 32'd1;
                    if (packet_left != 8'd0)
                        packet_left = packet_left - 8'd1;
                end
                pixels_left = pixels_left - count;
                px = make_pixel(count, pixels_left == 32'd0);
                if (pixels_left == 32'd0)
                    state = ST_DONE;
                else if (packet_left == 8'd0)
                    state = ST_RLE_HDR;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t px;
        out_item_t want;
        if (!rst_n)
        begin
            state       = ST_HEADER;
            hdr_pos     = 5'd0;
            skip_left   = 9'd0;
            rle         = 1'b0;
            width       = 16'd0;
            height      = 16'd0;
            depth       = 8'd0;
            pix_word    = 32'd0;
            byte_idx    = 2'd0;
            packet_left = 8'd0;
            packet_run  = 1'b0;
            pixels_left = 32'd0;
            expected_pixels.delete();
            mismatches  = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("result transaction with nothing expected: %h", result);
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("red", want.red, result.red);
                    check_field("green", want.green, result.green);
                    check_field("blue", want.blue, result.blue);
                    check_field("alpha", want.alpha, result.alpha);
                    check_field("has_alpha", want.has_alpha, result.has_alpha);
                    check_field("repeat_count", want.repeat_count, result.repeat_count);
                    check_field("last_pixel", want.last_pixel, result.last_pixel);
                    check_field("format_error", want.format_error, result.format_error);
                end
            end
            if (push && !full)
            begin
                if (decode_byte(item, px))
                    expected_pixels.push_back(px);
            end
        end
        outstanding = expected_pixels.size();
    end

endmodule

// ===== tb/tb_tga_pixel_stream_decoder.sv =====
`timescale 1ns / 1ps
// Top of the TGA pixel stream decoder testbench: clock, reset, byte stimulus,
// result popping and verdict. Depends on tgapsd_pkg and tga_pixel_checker.
module tb_tga_pixel_stream_decoder;
    import tgapsd_pkg::*;

    localparam logic [7:0] IMAGE_TYPE_RLE = 8'd10;
    localparam logic [7:0] IMAGE_TYPE_RGB = 8'd2;
    localparam int HOLD_CYCLES     = 80;
    localparam int DRAIN_CYCLES    = 20;
    localparam int BYTES_PER_PHASE = 210;
    localparam int NO_LIMIT        = 32'h7fff_ffff;

    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      pop = 1'b0;
    logic      full;
    logic      empty;
    in_item_t  item = '0;
    out_item_t result;
    int        mismatches;
    int        outstanding;

    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    stall_requests = 0;
    int    bytes_sent = 0;
    fill_t fill_mode = FILL_RANDOM;

    tga_pixel_stream_decoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    tga_pixel_checker #(
        .IMAGE_TYPE_RLE (IMAGE_TYPE_RLE)
    ) pixel_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .item        (item),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver; a stall request holds pop low for a long stretch
    initial
    begin : receiver
        int stalls_served;
        stalls_served = 0;
        forever
        begin
            @(negedge clk);
            if (stall_requests != stalls_served)
            begin
                stalls_served = stall_requests;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [7:0] body_byte();
        case (fill_mode)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic sof);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= {d, sof};
        @(posedge clk);
        while (full)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_pixel(input logic [7:0] depth);
        repeat (int'(depth[5:3]))
            send_byte(body_byte(), 1'b0);
    endtask

    task automatic send_header(input logic sof0, input logic [7:0] img_type, depth,
                               input logic [15:0] w, h, input logic [7:0] id_len);
        send_byte(id_len, sof0);
        send_byte(8'($urandom_range(1)), 1'b0);
        send_byte(img_type, 1'b0);
        repeat (9)
            send_byte(8'($urandom_range(255)), 1'b0);
        send_byte(w[7:0], 1'b0);
        send_byte(w[15:8], 1'b0);
        send_byte(h[7:0], 1'b0);
        send_byte(h[15:8], 1'b0);
        send_byte(depth, 1'b0);
        repeat (int'(id_len) + 1)
            send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic send_image(input logic sof0, input logic [7:0] img_type, depth,
                              input logic [15:0] w, h, input logic [7:0] id_len,
                              input int budget, input int max_packet);
        longint left;
        int     cnt;
        bit     run;
        send_header(sof0, img_type, depth, w, h, id_len);
        left = longint'(w) * longint'(h);
        if (!(depth == 8'd24 || depth == 8'd32 ||
              (img_type != IMAGE_TYPE_RLE && depth == 8'd16)))
            left = 0;
        while (left > 0 && budget > 0)
        begin
            if (img_type != IMAGE_TYPE_RLE)
            begin
                send_pixel(depth);
                left--;
                budget -= int'(depth[5:3]);
            end
            else
            begin
                cnt = $urandom_range(max_packet, 1);
                run = $urandom_range(1);
                send_byte(run ? 8'(cnt + 127) : 8'(cnt - 1), 1'b0);
                budget--;
                if (run)
                begin
                    send_pixel(depth);
                    left -= cnt;
                    budget -= int'(depth[5:3]);
                end
                else
                begin
                    for (int k = 0; k < cnt && left > 0; k++)
                    begin
                        send_pixel(depth);
                        left--;
                        budget -= int'(depth[5:3]);
                    end
                end
            end
        end
    endtask

    task automatic random_file();
        int          pick;
        logic [7:0]  img_type;
        logic [7:0]  depth;
        logic [7:0]  id_len;
        logic [15:0] w;
        logic [15:0] h;
        pick   = $urandom_range(99);
        id_len = ($urandom_range(49) == 0) ? 8'($urandom_range(255))
                                           : 8'($urandom_range(3));
        w = 16'($urandom_range(6, 1));
        h = 16'($urandom_range(6, 1));
        if ($urandom_range(1))
        begin
            img_type = IMAGE_TYPE_RLE;
            depth = $urandom_range(1) ? 8'd24 : 8'd32;
        end
        else
        begin
            do
                img_type = 8'($urandom_range(255));
            while (img_type == IMAGE_TYPE_RLE);
            case ($urandom_range(2))
                0:       depth = 8'd16;
                1:       depth = 8'd24;
                default: depth = 8'd32;
            endcase
        end
        if (pick < 80)
            send_image(1'b1, img_type, depth, w, h, id_len, NO_LIMIT,
                       $urandom_range(1) ? 4 : 128);
        else if (pick < 86)
        begin
            w = 16'($urandom_range(65535, 1));
            h = 16'($urandom_range(65535, 64));
            send_image(1'b1, img_type, depth, w, h, id_len, $urandom_range(40), 4);
        end
        else if (pick < 91)
        begin
            if (img_type == IMAGE_TYPE_RLE && $urandom_range(1))
                depth = 8'd16;
            else
                do
                    depth = 8'($urandom_range(255));
                while (depth == 8'd16 || depth == 8'd24 || depth == 8'd32);
            send_image(1'b1, img_type, depth, w, h, id_len, NO_LIMIT, 4);
        end
        else if (pick < 95)
        begin
            if ($urandom_range(1))
            begin
                w = 16'd0;
                h = 16'($urandom_range(65535));
            end
            else
            begin
                w = 16'($urandom_range(65535));
                h = 16'd0;
            end
            send_image(1'b1, img_type, depth, w, h, id_len, NO_LIMIT, 4);
        end
        else
        begin
            repeat ($urandom_range(12, 1))
                send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
        end
        repeat ($urandom_range(2))
            send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic settle();
        push <= 1'b0;
        wait (outstanding == 0);
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int target;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 27;
        recv_idle_pct = 51;

        // first file carries no start mark
        send_image(1'b0, IMAGE_TYPE_RGB, 8'd24, 16'd2, 16'd2, 8'd0, NO_LIMIT, 1);
        fill_mode = FILL_ONES;
        send_image(1'b1, IMAGE_TYPE_RGB, 8'd32, 16'd2, 16'd1, 8'd1, NO_LIMIT, 1);
        send_image(1'b1, IMAGE_TYPE_RGB, 8'd16, 16'd1, 16'd1, 8'd0, NO_LIMIT, 1);
        fill_mode = FILL_ZERO;
        send_image(1'b1, IMAGE_TYPE_RGB, 8'd16, 16'd1, 16'd2, 8'd0, NO_LIMIT, 1);
        fill_mode = FILL_RANDOM;

        // longest runs, then a raw packet past the last pixel, then a clamped run
        send_header(1'b1, IMAGE_TYPE_RLE, 8'd24, 16'd16, 16'd16, 8'd0);
        repeat (2)
        begin
            send_byte(8'hFF, 1'b0);
            send_pixel(8'd24);
        end
        send_header(1'b1, IMAGE_TYPE_RLE, 8'd32, 16'd4, 16'd4, 8'd2);
        send_byte(8'h7F, 1'b0);
        repeat (16) send_pixel(8'd32);
        send_byte(body_byte(), 1'b0);
        send_header(1'b1, IMAGE_TYPE_RLE, 8'd24, 16'd8, 16'd8, 8'd0);
        send_byte(8'h80, 1'b0);
        send_pixel(8'd24);
        send_byte(8'h00, 1'b0);
        send_pixel(8'd24);
        send_byte(8'hFF, 1'b0);
        send_pixel(8'd24);

        // unsupported depths
        send_header(1'b1, IMAGE_TYPE_RLE, 8'd16, 16'd2, 16'd2, 8'd0);
        send_pixel(8'd16);
        send_header(1'b1, IMAGE_TYPE_RGB, 8'd8, 16'd2, 16'd2, 8'd0);
        send_header(1'b1, IMAGE_TYPE_RGB, 8'd0, 16'd1, 16'd1, 8'd0);
        send_header(1'b1, IMAGE_TYPE_RLE, 8'd255, 16'd1, 16'd1, 8'd0);

        // zero area
        send_header(1'b1, IMAGE_TYPE_RGB, 8'd24, 16'hFFFF, 16'd0, 8'd0);
        repeat (6) send_byte(body_byte(), 1'b0);
        send_header(1'b1, IMAGE_TYPE_RLE, 8'd32, 16'd0, 16'hFFFF, 8'd0);
        repeat (6) send_byte(body_byte(), 1'b0);

        // restart mid-image and mid-header, then the longest id field
        send_header(1'b1, IMAGE_TYPE_RGB, 8'd24, 16'h8000, 16'h0101, 8'd0);
        repeat (4) send_pixel(8'd24);
        send_byte(8'd0, 1'b1);
        repeat (6) send_byte(body_byte(), 1'b0);
        send_image(1'b1, IMAGE_TYPE_RGB, 8'd24, 16'd1, 16'd1, 8'hFF, NO_LIMIT, 1);

        target = bytes_sent + BYTES_PER_PHASE;
        while (bytes_sent < target)
            random_file();
        settle();

        send_idle_pct = 51;
        recv_idle_pct = 27;
        target = bytes_sent + BYTES_PER_PHASE;
        while (bytes_sent < target)
            random_file();
        settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        target = bytes_sent + BYTES_PER_PHASE;
        stall_requests++;
        send_image(1'b1, IMAGE_TYPE_RGB, 8'd24, 16'd8, 16'd8, 8'd0, NO_LIMIT, 1);
        while (bytes_sent < target)
            random_file();
        settle();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("tb_tga_pixel_stream_decoder: done, clean");
        else
            $display("tb_tga_pixel_stream_decoder: done, errors");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("tb_tga_pixel_stream_decoder: done, errors");
        $finish;
    end

endmodule
